### design/psht_pkg.sv
// Shared types and constants for the polar sector hit test.
// Holds register codes, fixed field widths and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package psht_pkg;

  // Fixed widths of the configuration registers and result fields.
  localparam int CFG_COORD_W = 10;
  localparam int CFG_COUNT_W = 7;
  localparam int CFG_GAP_W   = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int RAD2_W      = 2 * CFG_COORD_W;
  localparam int SECTOR_IDX_W = 6;
  localparam int Z_W         = 32;
  localparam int ATAN_ENTRIES = 20;

  // Register reset values.
  localparam logic [CFG_COORD_W-1:0] CENTER_X_RST = 10'd120;
  localparam logic [CFG_COORD_W-1:0] CENTER_Y_RST = 10'd120;
  localparam logic [CFG_COORD_W-1:0] OUTER_R_RST  = 10'd120;
  localparam logic [CFG_COORD_W-1:0] INNER_R_RST  = 10'd0;
  localparam logic [CFG_COUNT_W-1:0] COUNT_RST    = 7'd12;
  localparam logic [CFG_GAP_W-1:0]   GAP_RST      = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_OUTER_RADIUS = 3'd2,
    CFG_INNER_RADIUS = 3'd3,
    CFG_SECTOR_COUNT = 3'd4,
    CFG_GAP_ANGLE    = 3'd5
  } psht_cfg_e;

  // Side information that travels with a point through the pipeline.
  typedef struct packed {
    logic in_ring;    // distance lies within both radii
    logic at_center;  // point sits exactly on the dial centre
  } psht_flags_t;

  // atan(2^-i) in units of 2^-32 of a full turn.
  localparam logic [Z_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

endpackage

`default_nettype wire

### design/psht_cordic_cell.sv
// One vectoring CORDIC step as a registered cell of the angle chain.
// Depends on psht_pkg for the flag struct and the arctangent table.
`default_nettype none

module psht_cordic_cell #(
  parameter int XW    = 28,
  parameter int SHIFT = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [XW-1:0]     x_i,
  input  logic signed [XW-1:0]     y_i,
  input  logic [psht_pkg::Z_W-1:0] z_i,
  input  psht_pkg::psht_flags_t    flags_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [XW-1:0]     x_o,
  output logic signed [XW-1:0]     y_o,
  output logic [psht_pkg::Z_W-1:0] z_o,
  output psht_pkg::psht_flags_t    flags_o
);
  import psht_pkg::*;

  localparam logic [Z_W-1:0] ATAN = ATAN_TURNS[SHIFT];

  logic                 valid_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic [Z_W-1:0]       z_q, z_d;
  psht_flags_t          flags_q;

  assign ready_o = !valid_q || ready_i;

  // Arithmetic shifts round towards minus infinity.
  assign xs = x_i >>> SHIFT;
  assign ys = y_i >>> SHIFT;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

### design/psht_front.sv
// Front end: offsets from the centre, ring test and the CORDIC start vector.
// Three registered stages. Depends on psht_pkg.
`default_nettype none

module psht_front #(
  parameter int COORD_BITS    = 10,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [COORD_BITS-1:0]             point_x_i,
  input  logic [COORD_BITS-1:0]             point_y_i,
  input  logic [psht_pkg::CFG_COORD_W-1:0]  center_x_i,
  input  logic [psht_pkg::CFG_COORD_W-1:0]  center_y_i,
  input  logic [psht_pkg::RAD2_W-1:0]       hi2_i,
  input  logic [psht_pkg::RAD2_W-1:0]       lo2_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [((COORD_BITS > psht_pkg::CFG_COORD_W) ? COORD_BITS
                        : psht_pkg::CFG_COORD_W) + CORDIC_STAGES + 2:0] x_o,
  output logic signed [((COORD_BITS > psht_pkg::CFG_COORD_W) ? COORD_BITS
                        : psht_pkg::CFG_COORD_W) + CORDIC_STAGES + 2:0] y_o,
  output logic [psht_pkg::Z_W-1:0]          z_o,
  output psht_pkg::psht_flags_t             flags_o
);
  import psht_pkg::*;

  localparam int DW  = ((COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W) + 1;
  localparam int XW  = DW + CORDIC_STAGES + 2;
  localparam int SQW = 2 * DW - 2;
  localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;

  // Stage 0: centre offsets.
  logic                 v0_q, r0;
  logic signed [DW-1:0] dx_q, dy_q;

  // Stage 1: squares and the start vector.
  logic                   v1_q, r1;
  logic [SQW-1:0]         sqx_q, sqy_q;
  logic signed [2*DW-1:0] sqx_w, sqy_w;
  logic signed [XW-1:0]   dxe, dye, x1_d, y1_d, x1_q, y1_q;
  logic [Z_W-1:0]         z1_d, z1_q;
  logic                   ctr1_q;

  // Stage 2: ring test.
  logic                 v2_q, r2;
  logic [SQW:0]         d2;
  logic signed [XW-1:0] x2_q, y2_q;
  logic [Z_W-1:0]       z2_q;
  psht_flags_t          flags2_q;

  assign r2      = !v2_q || ready_i;
  assign r1      = !v1_q || r2;
  assign r0      = !v0_q || r1;
  assign ready_o = r0;

  assign sqx_w = dx_q * dx_q;
  assign sqy_w = dy_q * dy_q;
  assign dxe   = XW'(dx_q);
  assign dye   = XW'(dy_q);

  // A vector pointing downwards is first turned by a half turn.
  always_comb begin
    if (!dy_q[DW-1] && (dy_q != '0)) begin
      x1_d = dye <<< CORDIC_STAGES;
      y1_d = -(dxe <<< CORDIC_STAGES);
      z1_d = HALF_TURN;
    end else begin
      x1_d = -(dye <<< CORDIC_STAGES);
      y1_d = dxe <<< CORDIC_STAGES;
      z1_d = '0;
    end
  end

  assign d2 = (SQW+1)'(sqx_q) + (SQW+1)'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r0) begin
        v0_q <= valid_i;
      end
      if (r1) begin
        v1_q <= v0_q;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r0 && valid_i) begin
      dx_q <= DW'(point_x_i) - DW'(center_x_i);
      dy_q <= DW'(point_y_i) - DW'(center_y_i);
    end
    if (r1 && v0_q) begin
      sqx_q  <= sqx_w[SQW-1:0];
      sqy_q  <= sqy_w[SQW-1:0];
      x1_q   <= x1_d;
      y1_q   <= y1_d;
      z1_q   <= z1_d;
      ctr1_q <= (dx_q == '0) && (dy_q == '0);
    end
    if (r2 && v1_q) begin
      x2_q               <= x1_q;
      y2_q               <= y1_q;
      z2_q               <= z1_q;
      flags2_q.at_center <= ctr1_q;
      flags2_q.in_ring   <= !((d2 > (SQW+1)'(hi2_i)) || (d2 < (SQW+1)'(lo2_i)));
    end
  end

  assign valid_o = v2_q;
  assign x_o     = x2_q;
  assign y_o     = y2_q;
  assign z_o     = z2_q;
  assign flags_o = flags2_q;

endmodule

`default_nettype wire

### design/psht_sector.sv
// Back end: rounds the CORDIC angle, finds the nearest sector and its gap test.
// Three registered stages, the last one is the output register. Depends on psht_pkg.
`default_nettype none

module psht_sector #(
  parameter int ANGLE_BITS  = 16,
  parameter int MAX_SECTORS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [psht_pkg::Z_W-1:0]              z_i,
  input  psht_pkg::psht_flags_t                 flags_i,
  input  logic [$clog2(MAX_SECTORS+1)-1:0]      cnt_i,
  input  logic [psht_pkg::CFG_GAP_W+$clog2(MAX_SECTORS+1)-1:0] gaps_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic                                  hit_o,
  output logic [psht_pkg::SECTOR_IDX_W-1:0]     sector_index_o
);
  import psht_pkg::*;

  localparam int CNTW = $clog2(MAX_SECTORS + 1);
  localparam int GW   = CFG_GAP_W + CNTW;
  localparam int PW   = ANGLE_BITS + CNTW;
  localparam int CW   = ANGLE_BITS + CFG_GAP_W + 2;
  localparam logic [Z_W-1:0]        ROUND_Z = Z_W'(1) << (31 - ANGLE_BITS);
  localparam logic [PW:0]           HALF_P  = (PW+1)'(1) << (ANGLE_BITS - 1);
  localparam logic [ANGLE_BITS:0]   FULL_A  = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
  localparam logic [CFG_GAP_W:0]    FULL_G  = (CFG_GAP_W+1)'(1) << CFG_GAP_W;

  // Stage A: angle rounded to ANGLE_BITS.
  logic                  va_q, ra, ok_a_q;
  logic [Z_W-1:0]        zr;
  logic [ANGLE_BITS-1:0] ang_q;

  // Stage M: angle times sector count.
  logic          vm_q, rm, ok_m_q;
  logic [PW-1:0] p_q;

  // Stage O: result word.
  logic                    vo_q, ro, hit_q;
  logic [SECTOR_IDX_W-1:0] idx_q;

  // Sector resolution on the product.
  logic [PW:0]             psum;
  logic [CNTW:0]           q;
  logic [ANGLE_BITS-1:0]   low, dev;
  logic [ANGLE_BITS:0]     neg;
  logic [CW-1:0]           lhs, rhs;
  logic                    ang_ok;
  logic [CNTW-1:0]         idx;
  logic [CNTW+SECTOR_IDX_W-1:0] idx_w;

  assign ro      = !vo_q || ready_i;
  assign rm      = !vm_q || ro;
  assign ra      = !va_q || rm;
  assign ready_o = ra;

  assign zr = z_i + ROUND_Z;

  // Nearest sector: round half up; deviation is distance to that centre.
  assign psum = (PW+1)'(p_q) + HALF_P;
  assign q    = psum[PW:ANGLE_BITS];
  assign low  = p_q[ANGLE_BITS-1:0];
  assign neg  = FULL_A - (ANGLE_BITS+1)'(low);
  assign dev  = low[ANGLE_BITS-1] ? neg[ANGLE_BITS-1:0] : low;

  // Within half a span less the gap: 2 * dev * 2^16 <= (2^16 - gap * cnt) * 2^AB.
  always_comb begin
    lhs = CW'(dev) << (CFG_GAP_W + 1);
    rhs = '0;
    if (gaps_i[GW-1:CFG_GAP_W] == '0) begin
      rhs    = CW'(FULL_G - (CFG_GAP_W+1)'(gaps_i[CFG_GAP_W-1:0])) << ANGLE_BITS;
      ang_ok = lhs <= rhs;
    end else begin
      ang_ok = dev == '0;
    end
  end

  // A rounded index equal to the count wraps to sector zero.
  assign idx   = (q == (CNTW+1)'(cnt_i)) ? '0 : q[CNTW-1:0];
  assign idx_w = (CNTW+SECTOR_IDX_W)'(idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ra) begin
        va_q <= valid_i;
      end
      if (rm) begin
        vm_q <= va_q;
      end
      if (ro) begin
        vo_q <= vm_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ra && valid_i) begin
      ang_q  <= flags_i.at_center ? '0 : zr[Z_W-1:Z_W-ANGLE_BITS];
      ok_a_q <= flags_i.in_ring;
    end
    if (rm && va_q) begin
      p_q    <= PW'(ang_q) * PW'(cnt_i);
      ok_m_q <= ok_a_q && (cnt_i != '0);
    end
    if (ro && vm_q) begin
      hit_q <= ok_m_q && ang_ok;
      idx_q <= (ok_m_q && ang_ok) ? idx_w[SECTOR_IDX_W-1:0] : '0;
    end
  end

  assign valid_o        = vo_q;
  assign hit_o          = hit_q;
  assign sector_index_o = idx_q;

endmodule

`default_nettype wire

### design/polar_sector_hit_test.sv
// Polar sector hit test: top level with configuration registers and the
// CORDIC cell chain. Depends on psht_pkg, psht_front, psht_cordic_cell, psht_sector.
//
// Usage
//   A point word (point_x_i, point_y_i) is taken at a rising edge where
//   in_valid_i is high and in_stall_o is low. Each point produces exactly one
//   result word (hit_o, sector_index_o), offered with out_valid_o and taken at
//   an edge where out_stall_i is low. A missed point reports hit 0, index 0.
//   The configuration port writes register cfg_index_i with cfg_wdata_i on
//   every edge where cfg_we_i is high; unknown indexes are ignored. Registers
//   should only be written while no point is in flight.
//   The pipeline has CORDIC_STAGES + 6 register stages. Throughput is one
//   word per cycle while out_stall_i stays low: every stage is its own
//   register and the chain holds up to CORDIC_STAGES + 6 points at once,
//   one per stage.
//   When the receiver stalls, the output register holds its word and the
//   stall works its way back stage by stage; empty stages keep filling, so
//   in_stall_o rises only once every stage is occupied.
//   Reset clears all stage valid flags and loads the register defaults:
//   centre (120, 120), outer radius 120, inner radius 0, twelve sectors and
//   no gap.
`default_nettype none

module polar_sector_hit_test #(
  parameter int COORD_BITS    = 10,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int MAX_SECTORS   = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [psht_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [psht_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // Point channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [COORD_BITS-1:0]               point_x_i,
  input  logic [COORD_BITS-1:0]               point_y_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [psht_pkg::SECTOR_IDX_W-1:0]   sector_index_o
);
  import psht_pkg::*;

  localparam int DW   = ((COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W) + 1;
  localparam int XW   = DW + CORDIC_STAGES + 2;
  localparam int CNTW = $clog2(MAX_SECTORS + 1);
  localparam int SCW  = (CNTW > CFG_COUNT_W) ? CNTW : CFG_COUNT_W;
  localparam int GW   = CFG_GAP_W + CNTW;

  // Configuration registers.
  logic [CFG_COORD_W-1:0] center_x_q, center_y_q, outer_q, inner_q;
  logic [CFG_COUNT_W-1:0] count_q;
  logic [CFG_GAP_W-1:0]   gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      outer_q    <= OUTER_R_RST;
      inner_q    <= INNER_R_RST;
      count_q    <= COUNT_RST;
      gap_q      <= GAP_RST;
    end else if (cfg_we_i) begin
      unique case (psht_cfg_e'(cfg_index_i))
        CFG_CENTER_X:     center_x_q <= cfg_wdata_i[CFG_COORD_W-1:0];
        CFG_CENTER_Y:     center_y_q <= cfg_wdata_i[CFG_COORD_W-1:0];
        CFG_OUTER_RADIUS: outer_q    <= cfg_wdata_i[CFG_COORD_W-1:0];
        CFG_INNER_RADIUS: inner_q    <= cfg_wdata_i[CFG_COORD_W-1:0];
        CFG_SECTOR_COUNT: count_q    <= cfg_wdata_i[CFG_COUNT_W-1:0];
        CFG_GAP_ANGLE:    gap_q      <= cfg_wdata_i[CFG_GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived terms. The radii are ordered so that the larger one bounds the
  // ring from outside, and the count is clamped to the sector limit. These
  // registers follow the configuration in the next cycle, well before any
  // point reaches the stages that read them.
  logic [CFG_COORD_W-1:0] hi_r, lo_r;
  logic [RAD2_W-1:0]      hi2_q, lo2_q;
  logic [SCW-1:0]         count_ext;
  logic [CNTW-1:0]        cnt;
  logic [GW-1:0]          gaps_q;

  assign hi_r      = (outer_q >= inner_q) ? outer_q : inner_q;
  assign lo_r      = (outer_q >= inner_q) ? inner_q : outer_q;
  assign count_ext = SCW'(count_q);
  assign cnt       = (count_ext > SCW'(MAX_SECTORS)) ? CNTW'(MAX_SECTORS)
                                                     : count_ext[CNTW-1:0];

  always_ff @(posedge clk_i) begin
    hi2_q  <= RAD2_W'(hi_r) * RAD2_W'(hi_r);
    lo2_q  <= RAD2_W'(lo_r) * RAD2_W'(lo_r);
    gaps_q <= GW'(gap_q) * GW'(cnt);
  end

  // Stage links: index 0 is the front end output, index k+1 the output of
  // CORDIC cell k.
  logic                 c_valid [CORDIC_STAGES+1];
  logic                 c_ready [CORDIC_STAGES+1];
  logic signed [XW-1:0] c_x     [CORDIC_STAGES+1];
  logic signed [XW-1:0] c_y     [CORDIC_STAGES+1];
  logic [Z_W-1:0]       c_z     [CORDIC_STAGES+1];
  psht_flags_t          c_flags [CORDIC_STAGES+1];
  logic                 front_ready;

  psht_front #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (front_ready),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .center_x_i(center_x_q),
    .center_y_i(center_y_q),
    .hi2_i     (hi2_q),
    .lo2_i     (lo2_q),
    .valid_o   (c_valid[0]),
    .ready_i   (c_ready[0]),
    .x_o       (c_x[0]),
    .y_o       (c_y[0]),
    .z_o       (c_z[0]),
    .flags_o   (c_flags[0])
  );

  assign in_stall_o = !front_ready;

  // Each cell applies one micro-rotation and hands its vector on.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    psht_cordic_cell #(
      .XW   (XW),
      .SHIFT(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(c_valid[k]),
      .ready_o(c_ready[k]),
      .x_i    (c_x[k]),
      .y_i    (c_y[k]),
      .z_i    (c_z[k]),
      .flags_i(c_flags[k]),
      .valid_o(c_valid[k+1]),
      .ready_i(c_ready[k+1]),
      .x_o    (c_x[k+1]),
      .y_o    (c_y[k+1]),
      .z_o    (c_z[k+1]),
      .flags_o(c_flags[k+1])
    );
  end

  psht_sector #(
    .ANGLE_BITS (ANGLE_BITS),
    .MAX_SECTORS(MAX_SECTORS)
  ) u_sector (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (c_valid[CORDIC_STAGES]),
    .ready_o       (c_ready[CORDIC_STAGES]),
    .z_i           (c_z[CORDIC_STAGES]),
    .flags_i       (c_flags[CORDIC_STAGES]),
    .cnt_i         (cnt),
    .gaps_i        (gaps_q),
    .valid_o       (out_valid_o),
    .ready_i       (!out_stall_i),
    .hit_o         (hit_o),
    .sector_index_o(sector_index_o)
  );

  // The final vector components are not needed; only the angle accumulator is.
  logic unused_xy;
  assign unused_xy = ^{c_x[CORDIC_STAGES], c_y[CORDIC_STAGES]};

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for polar_sector_hit_test: directed points, then random dial settings and points.
// Depends on psht_pkg and polar_sector_hit_test. A local bearing/sector predictor checks each word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psht_pkg::*;

  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int MAX_SECTORS   = 64;
  localparam int GAP_SHIFT     = 16;
  localparam int COORD_MAX     = (1 << CFG_COORD_W) - 1;
  // The pipeline is CORDIC_STAGES + 6 deep; the tail wait lets it settle.
  localparam int TAIL_CYCLES   = 2 * (CORDIC_STAGES + 6);
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int PHASES        = 12;
  localparam int PHASE_POINTS  = 63;
  localparam int DIRECTED_ROWS = 39;
  // Register index that decodes to nothing; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  // A full turn in the fine angle units used for the sector arithmetic.
  localparam longint FULL_TURN = 64'sh1_0000_0000;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32.
  localparam logic [31:0] ATAN_STEP [20] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  // One result word as the block reports it.
  typedef struct packed {
    logic                    hit;
    logic [SECTOR_IDX_W-1:0] index;
  } dial_hit_t;

  typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_e;

  // A directed row either writes a register or sends a point. For points whose
  // outcome is obvious (center, cardinal directions, clear misses) the
  // expected word is typed in; the rest go through the predictor.
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  wdata;
    logic [CFG_COORD_W-1:0] px;
    logic [CFG_COORD_W-1:0] py;
    logic                   typed;
    dial_hit_t              want;
  } stim_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [CFG_COORD_W-1:0]  point_x_i;
  logic [CFG_COORD_W-1:0]  point_y_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    hit_o;
  logic [SECTOR_IDX_W-1:0] sector_index_o;

  // Our own copy of the dial registers, updated on every write we make.
  logic [CFG_COORD_W-1:0] dial_cx;
  logic [CFG_COORD_W-1:0] dial_cy;
  logic [CFG_COORD_W-1:0] dial_outer;
  logic [CFG_COORD_W-1:0] dial_inner;
  logic [CFG_COUNT_W-1:0] dial_count;
  logic [CFG_GAP_W-1:0]   dial_gap;

  dial_hit_t expected_hits[$];
  int        fail_count  = 0;
  int        cycle_count = 0;
  // When set, neither side inserts idle cycles, so the pipeline runs full rate.
  logic      steady_flow = 1'b0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Reset dial: center (120,120), ring 0..120, twelve sectors, no gap.
    '{ROW_POINT, 3'd0, 16'd0, 10'd120, 10'd120, 1'b1, '{1'b1, 6'd0}},   // center point
    '{ROW_POINT, 3'd0, 16'd0, 10'd120, 10'd0,   1'b1, '{1'b1, 6'd0}},   // top, on outer bound
    '{ROW_POINT, 3'd0, 16'd0, 10'd240, 10'd120, 1'b1, '{1'b1, 6'd3}},   // three o'clock
    '{ROW_POINT, 3'd0, 16'd0, 10'd120, 10'd240, 1'b1, '{1'b1, 6'd6}},   // six o'clock
    '{ROW_POINT, 3'd0, 16'd0, 10'd0,   10'd120, 1'b1, '{1'b1, 6'd9}},   // nine o'clock
    '{ROW_POINT, 3'd0, 16'd0, 10'd241, 10'd120, 1'b1, '{1'b0, 6'd0}},   // one pixel outside
    '{ROW_POINT, 3'd0, 16'd0, 10'd1023, 10'd1023, 1'b1, '{1'b0, 6'd0}}, // far corner
    '{ROW_POINT, 3'd0, 16'd0, 10'd200, 10'd40,  1'b0, '{1'b0, 6'd0}},
    // Inner above outer: the ring becomes 120..130.
    '{ROW_WRITE, CFG_INNER_RADIUS, 16'd130, 10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd120, 10'd120, 1'b1, '{1'b0, 6'd0}},   // inside the hole
    '{ROW_POINT, 3'd0, 16'd0, 10'd245, 10'd120, 1'b1, '{1'b1, 6'd3}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd120, 10'd250, 1'b1, '{1'b1, 6'd6}},   // on the swapped bound
    // Upper data bits are dropped, so this write sets a count of zero.
    '{ROW_WRITE, CFG_SECTOR_COUNT, 16'hFF80, 10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd245, 10'd120, 1'b1, '{1'b0, 6'd0}},
    // A count above the limit acts as the limit.
    '{ROW_WRITE, CFG_SECTOR_COUNT, 16'd100, 10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd245, 10'd120, 1'b1, '{1'b1, 6'd16}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd210, 10'd30,  1'b0, '{1'b0, 6'd0}},
    // Two sectors with a half-turn gap: the gap swallows each sector.
    '{ROW_WRITE, CFG_SECTOR_COUNT, 16'd2,     10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_WRITE, CFG_GAP_ANGLE,    16'd32768, 10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd120, 10'd0,   1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd245, 10'd120, 1'b1, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd120, 10'd245, 1'b0, '{1'b0, 6'd0}},
    '{ROW_WRITE, REG_UNUSED, 16'hFFFF, 10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd0,   10'd60,  1'b0, '{1'b0, 6'd0}},
    // Dial in the bottom-left corner with the widest ring and the most sectors.
    '{ROW_WRITE, CFG_CENTER_X,     16'd0,    10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_WRITE, CFG_CENTER_Y,     16'hFFFF, 10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_WRITE, CFG_OUTER_RADIUS, 16'd1023, 10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_WRITE, CFG_INNER_RADIUS, 16'd0,    10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_WRITE, CFG_SECTOR_COUNT, 16'd64,   10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_WRITE, CFG_GAP_ANGLE,    16'd0,    10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd0,    10'd1023, 1'b1, '{1'b1, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd1023, 10'd1023, 1'b1, '{1'b1, 6'd16}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd0,    10'd0,    1'b1, '{1'b1, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd1023, 10'd0,    1'b1, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd1,    10'd0,    1'b0, '{1'b0, 6'd0}},
    // Largest gap: only points right on a sector center can hit.
    '{ROW_WRITE, CFG_GAP_ANGLE, 16'hFFFF, 10'd0, 10'd0, 1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd0,    10'd0,    1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd1023, 10'd1023, 1'b0, '{1'b0, 6'd0}},
    '{ROW_POINT, 3'd0, 16'd0, 10'd512,  10'd511,  1'b0, '{1'b0, 6'd0}}
  };

  polar_sector_hit_test DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .sector_index_o (sector_index_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Clockwise-from-top bearing of (dx, dy) in 16-bit turn units. Vectoring
  // CORDIC on the vector (up, right) = (-dy, dx), scaled by 2^CORDIC_STAGES;
  // a vector in the lower half plane is first turned half a turn. The 32-bit
  // phase is rounded half up to the output width and wraps at a full turn.
  function automatic logic [ANGLE_BITS-1:0] bearing(input longint dx, input longint dy);
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] z;
    if (dx == 0 && dy == 0) begin
      return '0;
    end
    x = -dy * (longint'(1) <<< CORDIC_STAGES);
    y = dx * (longint'(1) <<< CORDIC_STAGES);
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      // Arithmetic shifts of signed values round towards minus infinity.
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end
    end
    z = z + (32'd1 << (31 - ANGLE_BITS));
    return z[31 -: ANGLE_BITS];
  endfunction

  // Works out the word the block should report for one point under the
  // current dial settings. Sector math is exact in units of 2^-32 turn.
  function automatic dial_hit_t predict_hit(input logic [CFG_COORD_W-1:0] px,
                                            input logic [CFG_COORD_W-1:0] py);
    longint    dx;
    longint    dy;
    longint    d2;
    longint    hi;
    longint    lo;
    longint    swap;
    longint    cnt;
    longint    a;
    longint    q;
    longint    dev;
    longint    gaps;
    logic      in_span;
    dial_hit_t r;
    r  = '0;
    dx = longint'(px) - longint'(dial_cx);
    dy = longint'(py) - longint'(dial_cy);
    hi = longint'(dial_outer);
    lo = longint'(dial_inner);
    if (hi < lo) begin
      swap = hi;
      hi   = lo;
      lo   = swap;
    end
    d2 = dx * dx + dy * dy;
    if (d2 > hi * hi || d2 < lo * lo) begin
      return r;
    end
    cnt = longint'(dial_count);
    if (cnt > MAX_SECTORS) begin
      cnt = longint'(MAX_SECTORS);
    end
    if (cnt == 0) begin
      return r;
    end
    // Nearest sector center, rounding half up, and the distance to it.
    a   = longint'(bearing(dx, dy)) <<< GAP_SHIFT;
    q   = (a * cnt + FULL_TURN / 2) / FULL_TURN;
    dev = a * cnt - q * FULL_TURN;
    if (dev < 0) begin
      dev = -dev;
    end
    gaps = longint'(dial_gap) * (longint'(1) <<< ANGLE_BITS) * cnt;
    if (FULL_TURN > gaps) begin
      in_span = (2 * dev <= FULL_TURN - gaps);
    end else begin
      in_span = (dev == 0);
    end
    if (in_span) begin
      r.hit   = 1'b1;
      r.index = SECTOR_IDX_W'(q % cnt);
    end
    return r;
  endfunction

  // Idle cycles before the next word on either side; none in steady phases,
  // otherwise about half the words go straight through.
  function automatic int idle_cycles();
    if (steady_flow || $urandom_range(0, 1) == 0) begin
      return 0;
    end
    return $urandom_range(1, 6);
  endfunction

  // Writes one register and mirrors it into the local dial copy. Called at a
  // rising edge; returns with the write enable low again.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_CENTER_X:     dial_cx    = data[CFG_COORD_W-1:0];
      CFG_CENTER_Y:     dial_cy    = data[CFG_COORD_W-1:0];
      CFG_OUTER_RADIUS: dial_outer = data[CFG_COORD_W-1:0];
      CFG_INNER_RADIUS: dial_inner = data[CFG_COORD_W-1:0];
      CFG_SECTOR_COUNT: dial_count = data[CFG_COUNT_W-1:0];
      CFG_GAP_ANGLE:    dial_gap   = data[CFG_GAP_W-1:0];
      default: ;
    endcase
  endtask

  // Stops sending and waits until every expected word has come back, so the
  // pipeline is empty before registers change. Always waits for a clock edge
  // first so that a valid lowered here is never raised again in the same time step.
  task automatic settle_dial();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_hits.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Offers one point word after a random gap and holds it until it is taken.
  // The expected word is queued at the accepting edge. Valid stays high on
  // return so that back-to-back words need no second assignment.
  task automatic send_point(input logic [CFG_COORD_W-1:0] px,
                            input logic [CFG_COORD_W-1:0] py,
                            input dial_hit_t want);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i  <= px;
    point_y_i  <= py;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    expected_hits.push_back(want);
  endtask

  // Chooses a new dial while idle. The four flavors rotate: a centered ring
  // with small gaps, raw 16-bit data (upper bits must be dropped), corner
  // values of every register, and swapped radii with arbitrary gaps.
  task automatic retune_dial(input int phase);
    logic [CFG_DATA_W-1:0] cx;
    logic [CFG_DATA_W-1:0] cy;
    logic [CFG_DATA_W-1:0] ro;
    logic [CFG_DATA_W-1:0] ri;
    logic [CFG_DATA_W-1:0] cnt;
    logic [CFG_DATA_W-1:0] gap;
    case (phase % 4)
      0: begin
        cx  = CFG_DATA_W'($urandom_range(150, 870));
        cy  = CFG_DATA_W'($urandom_range(150, 870));
        ro  = CFG_DATA_W'($urandom_range(10, 150));
        ri  = CFG_DATA_W'($urandom_range(0, ro));
        cnt = CFG_DATA_W'($urandom_range(1, MAX_SECTORS));
        gap = CFG_DATA_W'($urandom_range(0, 32768 / int'(cnt)));
      end
      1: begin
        cx  = CFG_DATA_W'($urandom());
        cy  = CFG_DATA_W'($urandom());
        ro  = CFG_DATA_W'($urandom());
        ri  = CFG_DATA_W'($urandom());
        cnt = CFG_DATA_W'($urandom());
        gap = CFG_DATA_W'($urandom());
      end
      2: begin
        cx  = $urandom_range(0, 1) ? CFG_DATA_W'(COORD_MAX) : '0;
        cy  = $urandom_range(0, 1) ? CFG_DATA_W'(COORD_MAX) : '0;
        ro  = $urandom_range(0, 1) ? CFG_DATA_W'(COORD_MAX)
                                   : CFG_DATA_W'($urandom_range(0, 3));
        ri  = $urandom_range(0, 1) ? CFG_DATA_W'(COORD_MAX) : '0;
        case ($urandom_range(0, 3))
          0:       cnt = '0;
          1:       cnt = 16'd1;
          2:       cnt = CFG_DATA_W'(MAX_SECTORS);
          default: cnt = 16'd127;
        endcase
        gap = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        cx  = CFG_DATA_W'($urandom_range(200, 820));
        cy  = CFG_DATA_W'($urandom_range(200, 820));
        ri  = CFG_DATA_W'($urandom_range(40, 200));
        ro  = CFG_DATA_W'($urandom_range(0, ri));
        cnt = CFG_DATA_W'($urandom_range(1, 127));
        gap = CFG_DATA_W'($urandom_range(0, 65535));
      end
    endcase
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_OUTER_RADIUS, ro);
    write_reg(CFG_INNER_RADIUS, ri);
    write_reg(CFG_SECTOR_COUNT, cnt);
    write_reg(CFG_GAP_ANGLE, gap);
  endtask

  // Most random points land in the box around the ring, so that boundaries
  // and sector edges are met often; a quarter cover the whole screen.
  task automatic send_random_point();
    int span;
    int px;
    int py;
    if ($urandom_range(0, 3) == 0) begin
      px = $urandom_range(0, COORD_MAX);
      py = $urandom_range(0, COORD_MAX);
    end else begin
      span = ((dial_outer > dial_inner) ? int'(dial_outer) : int'(dial_inner)) + 2;
      px   = int'(dial_cx) + int'($urandom_range(0, 2 * span)) - span;
      py   = int'(dial_cy) + int'($urandom_range(0, 2 * span)) - span;
      px   = (px < 0) ? 0 : ((px > COORD_MAX) ? COORD_MAX : px);
      py   = (py < 0) ? 0 : ((py > COORD_MAX) ? COORD_MAX : py);
    end
    send_point(CFG_COORD_W'(px), CFG_COORD_W'(py),
               predict_hit(CFG_COORD_W'(px), CFG_COORD_W'(py)));
  endtask

  // Result side: before each word, hold stall high for a random number of
  // cycles, then release it until a word is taken.
  initial begin : result_sink
    int hold;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      hold = idle_cycles();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) begin
        @(posedge clk_i);
      end
    end
  end

  // Every word taken from the block is compared with the oldest expectation.
  always @(posedge clk_i) begin : score_results
    dial_hit_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        $display("%0t ns: unexpected result word, hit %0b index %0d",
                 $time, hit_o, sector_index_o);
        fail_count++;
      end else begin
        want = expected_hits.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t ns: hit mismatch, expected %0b, got %0b", $time, want.hit, hit_o);
          fail_count++;
        end
        if (sector_index_o !== want.index) begin
          $display("%0t ns: sector_index mismatch, expected %0d, got %0d",
                   $time, want.index, sector_index_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    dial_hit_t want;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_CENTER_X;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    point_x_i   = '0;
    point_y_i   = '0;
    dial_cx     = CENTER_X_RST;
    dial_cy     = CENTER_Y_RST;
    dial_outer  = OUTER_R_RST;
    dial_inner  = INNER_R_RST;
    dial_count  = COUNT_RST;
    dial_gap    = GAP_RST;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: register writes wait for an empty pipeline first.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        settle_dial();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].wdata);
      end else begin
        want = directed_rows[r].typed ? directed_rows[r].want
                                      : predict_hit(directed_rows[r].px, directed_rows[r].py);
        send_point(directed_rows[r].px, directed_rows[r].py, want);
      end
    end

    // Random part: each phase drains the pipeline, picks a new dial and
    // sends a batch of points. Every third phase runs without idle cycles.
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_dial();
      retune_dial(phase);
      steady_flow = (phase % 3 == 2);
      repeat (PHASE_POINTS) send_random_point();
    end

    settle_dial();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
